// ===== rtl/core/selb_pkg.sv =====
`default_nettype none
package selb_pkg;

  localparam int MAX_ROWS = 1024;
  localparam int WORD_BITS = 32;
  localparam int NWORDS = (MAX_ROWS + WORD_BITS - 1) / WORD_BITS;
  localparam int ROW_W = 11;
  localparam int IDX_W = $clog2(NWORDS);
  localparam int BIT_W = $clog2(WORD_BITS);

  typedef enum logic [3:0] {
    CMD_QUERY   = 4'd0,
    CMD_INSERT  = 4'd1,
    CMD_DELETE  = 4'd2,
    CMD_DEL_SEL = 4'd3,
    CMD_MOVE    = 4'd4,
    CMD_SET     = 4'd5,
    CMD_CLEAR   = 4'd6,
    CMD_TOGGLE  = 4'd7,
    CMD_SINGLE  = 4'd8,
    CMD_ALL     = 4'd9,
    CMD_RESIZE  = 4'd10
  } cmd_e;

  typedef enum logic [3:0] {
    OP_KEEP,
    OP_INS,
    OP_DEL,
    OP_SET,
    OP_CLR,
    OP_TOG,
    OP_ONE,
    OP_ALL,
    OP_ZERO
  } pass_op_e;

  typedef enum logic [1:0] {
    TGT_ROW,
    TGT_ROW2,
    TGT_RESEL
  } tgt_sel_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_PASS1,
    S_MID,
    S_PASS2,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [3:0]       cmd;
    logic [ROW_W-1:0] row;
    logic [ROW_W-1:0] row2;
  } req_t;

  typedef struct packed {
    logic             bit_value;
    logic [ROW_W-1:0] selected_count;
    logic [ROW_W-1:0] row_count;
    logic             error;
  } res_t;

  typedef struct packed {
    logic     load;
    logic     first;
    logic     begin_pass;
    pass_op_e op;
    tgt_sel_e tsel;
  } dp_ctl_t;

  typedef struct packed {
    logic             err;
    logic             pass_done;
    logic             was;
    logic [3:0]       cmd;
    logic [ROW_W-1:0] n;
  } dp_sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/selb_ctrl.sv =====
`default_nettype none
module selb_ctrl
  import selb_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start_i,
  input  wire dp_sts_t sts_i,
  output dp_ctl_t      ctl_o,
  output logic         busy_o,
  output logic         done_o
);

  state_e st_q, st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE: begin
        if (start_i) st_d = S_CHECK;
      end
      S_CHECK: st_d = S_PASS1;
      S_PASS1: begin
        if (sts_i.pass_done) st_d = S_MID;
      end
      S_MID: begin
        if (!sts_i.err && (sts_i.cmd == CMD_MOVE ||
            (sts_i.cmd == CMD_DEL_SEL && sts_i.was && sts_i.n != '0))) begin
          st_d = S_PASS2;
        end else begin
          st_d = S_DONE;
        end
      end
      S_PASS2: begin
        if (sts_i.pass_done) st_d = S_DONE;
      end
      S_DONE: st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctl_o = '{load: 1'b0, first: 1'b0, begin_pass: 1'b0, op: OP_KEEP, tsel: TGT_ROW};
    busy_o = (st_q != S_IDLE);
    done_o = (st_q == S_DONE);
    case (st_q)
      S_IDLE: ctl_o.load = start_i;
      S_CHECK: begin
        ctl_o.first = 1'b1;
        ctl_o.begin_pass = 1'b1;
        if (!sts_i.err) begin
          case (sts_i.cmd)
            CMD_INSERT:  ctl_o.op = OP_INS;
            CMD_DELETE:  ctl_o.op = OP_DEL;
            CMD_DEL_SEL: ctl_o.op = OP_DEL;
            CMD_MOVE:    ctl_o.op = OP_DEL;
            CMD_SET:     ctl_o.op = OP_SET;
            CMD_CLEAR:   ctl_o.op = OP_CLR;
            CMD_TOGGLE:  ctl_o.op = OP_TOG;
            CMD_SINGLE:  ctl_o.op = OP_ONE;
            CMD_ALL:     ctl_o.op = OP_ALL;
            CMD_RESIZE:  ctl_o.op = OP_ZERO;
            default:     ctl_o.op = OP_KEEP;
          endcase
        end
      end
      S_MID: begin
        if (st_d == S_PASS2) begin
          ctl_o.begin_pass = 1'b1;
          if (sts_i.cmd == CMD_MOVE) begin
            ctl_o.op = OP_INS;
            ctl_o.tsel = TGT_ROW2;
          end else begin
            ctl_o.op = OP_ONE;
            ctl_o.tsel = TGT_RESEL;
          end
        end
      end
      default: ;
    endcase
  end

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o) else $error("done not followed by idle");
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.load |-> !busy_o) else $error("load while busy");
  a_pass_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_PASS1 && sts_i.pass_done) |=> st_q == S_MID)
    else $error("pass end missed");

endmodule
`default_nettype wire

// ===== rtl/core/selb_dp.sv =====
`default_nettype none
module selb_dp
  import selb_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire req_t    req_i,
  input  wire dp_ctl_t ctl_i,
  output dp_sts_t      sts_o,
  output res_t         res_o
);

  localparam logic [ROW_W-1:0] MaxRows = ROW_W'(MAX_ROWS);

  function automatic logic [WORD_BITS-1:0] ge_mask(input logic [IDX_W-1:0] k,
                                                   input logic [ROW_W-1:0] v);
    logic [ROW_W-BIT_W-1:0] kk;
    logic [ROW_W-BIT_W-1:0] vw;
    kk = (ROW_W-BIT_W)'(k);
    vw = v[ROW_W-1:BIT_W];
    if (kk < vw) begin
      ge_mask = '0;
    end else if (kk > vw) begin
      ge_mask = '1;
    end else begin
      ge_mask = {WORD_BITS{1'b1}} >> v[BIT_W-1:0];
    end
  endfunction

  logic [WORD_BITS-1:0] words_q [NWORDS];
  req_t                 req_q;
  logic [ROW_W-1:0]     n_q;
  logic [ROW_W-1:0]     tgt_q;
  pass_op_e             op_q;
  logic                 run_q;
  logic [IDX_W-1:0]     cnt_q;
  logic                 carry_q;
  logic [ROW_W-1:0]     acc_q;
  logic                 err_q;
  logic                 was_q;
  logic                 nbit_q;

  logic                 err_c;
  logic                 desc;
  logic [IDX_W-1:0]     idx;
  logic [WORD_BITS-1:0] w;
  logic [WORD_BITS-1:0] nw;
  logic [WORD_BITS-1:0] m_lo;
  logic [WORD_BITS-1:0] m_hi;
  logic [WORD_BITS-1:0] m_one;
  logic [ROW_W-1:0]     tgt1;
  logic [ROW_W-1:0]     resel;
  logic [ROW_W-1:0]     tgt_d;
  logic                 last;
  logic                 hit_tgt;
  logic                 hit_row;

  always_comb begin
    err_c = 1'b0;
    case (req_q.cmd)
      CMD_INSERT:  err_c = (n_q >= MaxRows) || (req_q.row > n_q);
      CMD_DELETE,
      CMD_DEL_SEL,
      CMD_TOGGLE,
      CMD_SINGLE:  err_c = (req_q.row >= n_q);
      CMD_MOVE:    err_c = (req_q.row >= n_q) || (req_q.row2 >= n_q);
      CMD_SET,
      CMD_CLEAR:   err_c = (req_q.row > req_q.row2) || (req_q.row2 > n_q);
      CMD_RESIZE:  err_c = (req_q.row > MaxRows);
      default:     err_c = 1'b0;
    endcase
  end

  assign resel = (req_q.row == n_q) ? req_q.row - ROW_W'(1) : req_q.row;

  always_comb begin
    case (ctl_i.tsel)
      TGT_ROW2:  tgt_d = req_q.row2;
      TGT_RESEL: tgt_d = resel;
      default:   tgt_d = req_q.row;
    endcase
  end

  assign desc = (op_q == OP_DEL);
  assign idx = desc ? ~cnt_q : cnt_q;
  assign last = (cnt_q == IDX_W'(NWORDS - 1));
  assign w = words_q[idx];
  assign tgt1 = tgt_q + ROW_W'(1);
  assign m_lo = ge_mask(idx, tgt_q);
  assign m_hi = ge_mask(idx, (op_q == OP_SET || op_q == OP_CLR) ? req_q.row2 : tgt1);
  assign m_one = m_lo & ~m_hi;
  assign hit_tgt = ((ROW_W-BIT_W)'(idx) == tgt_q[ROW_W-1:BIT_W]);
  assign hit_row = ((ROW_W-BIT_W)'(idx) == req_q.row[ROW_W-1:BIT_W]);

  always_comb begin
    case (op_q)
      OP_INS:  nw = (w & ~m_lo) | ({carry_q, w[WORD_BITS-1:1]} & m_hi);
      OP_DEL:  nw = (w & ~m_lo) | ({w[WORD_BITS-2:0], carry_q} & m_lo);
      OP_SET:  nw = w | m_one;
      OP_CLR:  nw = w & ~m_one;
      OP_TOG:  nw = w ^ m_one;
      OP_ONE:  nw = m_one;
      OP_ALL:  nw = ~ge_mask(idx, n_q);
      OP_ZERO: nw = '0;
      default: nw = w;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NWORDS; i++) words_q[i] <= '0;
      n_q <= '0;
      run_q <= 1'b0;
      cnt_q <= '0;
      op_q <= OP_KEEP;
    end else begin
      if (ctl_i.begin_pass) begin
        run_q <= 1'b1;
        cnt_q <= '0;
        op_q <= ctl_i.op;
      end else if (run_q) begin
        words_q[idx] <= nw;
        cnt_q <= cnt_q + IDX_W'(1);
        if (last) begin
          run_q <= 1'b0;
          case (op_q)
            OP_INS:  n_q <= n_q + ROW_W'(1);
            OP_DEL:  n_q <= n_q - ROW_W'(1);
            OP_ZERO: n_q <= req_q.row;
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) req_q <= req_i;
    if (ctl_i.first) err_q <= err_c;
    if (ctl_i.begin_pass) begin
      tgt_q <= tgt_d;
      carry_q <= 1'b0;
      acc_q <= '0;
    end else if (run_q) begin
      carry_q <= desc ? w[WORD_BITS-1] : w[0];
      acc_q <= acc_q + ROW_W'($countones(nw));
      if (hit_tgt) was_q <= w[~tgt_q[BIT_W-1:0]];
      if (hit_row) nbit_q <= nw[~req_q.row[BIT_W-1:0]];
    end
  end

  assign sts_o = '{err: ctl_i.first ? err_c : err_q, pass_done: run_q && last,
                   was: was_q, cmd: req_q.cmd, n: n_q};

  assign res_o = '{bit_value: (req_q.row < n_q) ? nbit_q : 1'b0,
                   selected_count: acc_q, row_count: n_q, error: err_q};

  a_n_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= MaxRows) else $error("row count above maximum");
  a_begin_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.begin_pass |-> !run_q) else $error("pass started while running");
  a_err_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_q && err_q && !ctl_i.first) |=> $stable(n_q)) else $error("refused command changed count");

endmodule
`default_nettype wire

// ===== rtl/core/selection_bitmap_engine.sv =====
`default_nettype none
// Row-selection bitmap engine with a command interface.
// A command beat is taken at a rising edge where start_i is high and busy_o is
// low; req_i carries the command code, row and row2.
// The result beat is on res_o for exactly one cycle, marked by done_o, and the
// receiver must take it then, since it cannot stall the block.
// Every command sweeps the 32-word map one word per cycle through a single
// read-modify-write port, counting set bits on the way.
// A command goes through a check step, a first sweep and a mid step before the
// done_o cycle; a move, or a delete that reselects a row, adds a second sweep
// after the mid step.
// One command is in flight at a time; a new one is taken only once busy_o is
// low again.
// Reset clears the map and sets the row count to zero; no clearing pass is
// needed and a command may start in the first cycle after reset.
module selection_bitmap_engine
  import selb_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  wire req_t req_i,
  output logic      busy,
  output logic      busy_o,
  output logic      done_o,
  output res_t      res_o
);

  dp_ctl_t ctl;
  dp_sts_t sts;

  selb_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .sts_i  (sts),
    .ctl_o  (ctl),
    .busy_o (busy_o),
    .done_o (done_o)
  );

  selb_dp u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_i),
    .ctl_i (ctl),
    .sts_o (sts),
    .res_o (res_o)
  );

  assign busy = busy_o;

endmodule
`default_nettype wire

// ===== tb/sv/selection_bitmap_engine_tb.sv =====
`timescale 1ns / 1ps
module selection_bitmap_engine_tb;
  import selb_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  req_t req_i = '0;
  logic busy, busy_o, done_o;
  res_t res_o;

  selection_bitmap_engine i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .req_i(req_i),
    .busy(busy), .busy_o(busy_o), .done_o(done_o), .res_o(res_o)
  );

  always #4 clk_i = ~clk_i;

  logic [MAX_ROWS-1:0] sel_map;
  int unsigned         row_total;
  req_t                cmd_queue[$];
  res_t                answer_queue[$];
  int                  mismatch_count = 0;
  int                  gap_left = 0;
  bit                  quiet_tail = 1'b0;
  bit                  hold_send = 1'b0;
  bit                  stim_done = 1'b0;

  function automatic res_t apply_cmd(req_t rq);
    res_t        r;
    int unsigned row, row2, i;
    bit          was;
    bit          err;
    row = rq.row;
    row2 = rq.row2;
    err = 1'b0;
    case (rq.cmd)
      CMD_INSERT: begin
        if (row_total >= MAX_ROWS || row > row_total) err = 1'b1;
        else begin
          for (i = row_total; i > row; i--) sel_map[i] = sel_map[i-1];
          sel_map[row] = 1'b0;
          row_total++;
        end
      end
      CMD_DELETE, CMD_DEL_SEL: begin
        if (row >= row_total) err = 1'b1;
        else begin
          was = sel_map[row];
          for (i = row; i + 1 < row_total; i++) sel_map[i] = sel_map[i+1];
          sel_map[row_total-1] = 1'b0;
          row_total--;
          if (rq.cmd == CMD_DEL_SEL && was && row_total > 0) begin
            sel_map = '0;
            sel_map[(row == row_total) ? row - 1 : row] = 1'b1;
          end
        end
      end
      CMD_MOVE: begin
        if (row >= row_total || row2 >= row_total) err = 1'b1;
        else begin
          for (i = row; i + 1 < row_total; i++) sel_map[i] = sel_map[i+1];
          sel_map[row_total-1] = 1'b0;
          for (i = row_total - 1; i > row2; i--) sel_map[i] = sel_map[i-1];
          sel_map[row2] = 1'b0;
        end
      end
      CMD_SET, CMD_CLEAR: begin
        if (row > row2 || row2 > row_total) err = 1'b1;
        else for (i = row; i < row2; i++) sel_map[i] = (rq.cmd == CMD_SET);
      end
      CMD_TOGGLE: begin
        if (row >= row_total) err = 1'b1;
        else sel_map[row] = ~sel_map[row];
      end
      CMD_SINGLE: begin
        if (row >= row_total) err = 1'b1;
        else begin
          sel_map = '0;
          sel_map[row] = 1'b1;
        end
      end
      CMD_ALL: for (i = 0; i < row_total; i++) sel_map[i] = 1'b1;
      CMD_RESIZE: begin
        if (row > MAX_ROWS) err = 1'b1;
        else begin
          sel_map = '0;
          row_total = row;
        end
      end
      default: ;
    endcase
    r.bit_value = (row < row_total) ? sel_map[row] : 1'b0;
    r.selected_count = ROW_W'($countones(sel_map));
    r.row_count = ROW_W'(row_total);
    r.error = err;
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      answer_queue.push_back(apply_cmd(req_i));
    end
    if (start_i && !busy_o) begin
      if (cmd_queue.size() > 0 && !quiet_tail && $urandom_range(0, 9) == 0) begin
        gap_left <= $urandom_range(1, 19);
        start_i <= 1'b0;
      end else if (cmd_queue.size() > 0 && !hold_send) begin
        req_i <= cmd_queue.pop_front();
      end else begin
        start_i <= 1'b0;
      end
    end else if (!start_i && rst_ni) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (cmd_queue.size() > 0 && !hold_send) begin
        req_i <= cmd_queue.pop_front();
        start_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (done_o) begin
      if (answer_queue.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected beat %p", res_o);
      end else if (res_o !== answer_queue[0]) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("mismatch: expected %p actual %p", answer_queue[0], res_o);
        void'(answer_queue.pop_front());
      end else begin
        void'(answer_queue.pop_front());
      end
    end
  end

  function automatic req_t make_cmd(cmd_e c, int unsigned a, int unsigned b);
    req_t rq;
    rq.cmd = c;
    rq.row = ROW_W'(a);
    rq.row2 = ROW_W'(b);
    return rq;
  endfunction

  function automatic int unsigned pick_row();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 2047);
      1: return $urandom_range(0, 3);
      2: return $urandom_range(1000, 1024);
      default: return $urandom_range(0, 80);
    endcase
  endfunction

  initial begin
    int   n;
    req_t rq;
    cmd_queue.push_back(make_cmd(CMD_QUERY, 0, 0));
    cmd_queue.push_back(make_cmd(CMD_INSERT, 1, 0));
    cmd_queue.push_back(make_cmd(CMD_DELETE, 0, 0));
    cmd_queue.push_back(make_cmd(CMD_ALL, 0, 0));
    cmd_queue.push_back(make_cmd(CMD_RESIZE, 1025, 0));
    cmd_queue.push_back(make_cmd(CMD_RESIZE, 1024, 2047));
    cmd_queue.push_back(make_cmd(CMD_INSERT, 0, 0));
    cmd_queue.push_back(make_cmd(CMD_ALL, 0, 0));
    cmd_queue.push_back(make_cmd(CMD_DEL_SEL, 1023, 0));
    cmd_queue.push_back(make_cmd(CMD_SET, 0, 1023));
    cmd_queue.push_back(make_cmd(CMD_DEL_SEL, 5, 0));
    cmd_queue.push_back(make_cmd(CMD_DEL_SEL, 1021, 0));
    cmd_queue.push_back(make_cmd(CMD_MOVE, 0, 1021));
    cmd_queue.push_back(make_cmd(CMD_MOVE, 1022, 0));
    cmd_queue.push_back(make_cmd(CMD_CLEAR, 30, 30));
    cmd_queue.push_back(make_cmd(CMD_CLEAR, 31, 30));
    cmd_queue.push_back(make_cmd(CMD_CLEAR, 0, 1023));
    cmd_queue.push_back(make_cmd(CMD_TOGGLE, 31, 0));
    cmd_queue.push_back(make_cmd(CMD_TOGGLE, 2047, 0));
    cmd_queue.push_back(make_cmd(CMD_SINGLE, 32, 0));
    cmd_queue.push_back(make_cmd(CMD_SINGLE, 1022, 1024));
    cmd_queue.push_back(make_cmd(cmd_e'(4'd15), 32, 2047));
    cmd_queue.push_back(make_cmd(CMD_RESIZE, 0, 0));
    cmd_queue.push_back(make_cmd(CMD_DEL_SEL, 0, 0));
    cmd_queue.push_back(make_cmd(CMD_RESIZE, 1, 0));
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (n = 0; n < 1400; n++) begin
      if (n == 700) begin
        wait (cmd_queue.size() == 0);
        hold_send = 1'b1;
        @(posedge clk_i);
        wait (answer_queue.size() == 0 && !start_i);
        hold_send = 1'b0;
      end
      if ($urandom_range(0, 19) == 0) rq = make_cmd(CMD_RESIZE, $urandom_range(0, 100), 0);
      else if ($urandom_range(0, 49) == 0) rq = make_cmd(CMD_RESIZE, $urandom_range(990, 1024), 0);
      else if ($urandom_range(0, 29) == 0) begin
        rq.cmd = 4'($urandom_range(0, 15));
        rq.row = 11'($urandom);
        rq.row2 = 11'($urandom);
      end else begin
        rq.cmd = 4'($urandom_range(0, 9));
        rq.row = ROW_W'(pick_row());
        rq.row2 = ROW_W'(pick_row());
        if (rq.cmd inside {CMD_SET, CMD_CLEAR} && rq.row > rq.row2 && $urandom_range(0, 3) != 0)
          {rq.row, rq.row2} = {rq.row2, rq.row};
      end
      cmd_queue.push_back(rq);
    end
    stim_done = 1'b1;
    wait (cmd_queue.size() <= 150);
    quiet_tail = 1'b1;
  end

  initial begin
    wait (stim_done && cmd_queue.size() == 0 && !start_i && answer_queue.size() == 0);
    repeat (100) @(posedge clk_i);
    if (mismatch_count == 0 && answer_queue.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/selb_pkg.sv
rtl/core/selb_ctrl.sv
rtl/core/selb_dp.sv
rtl/core/selection_bitmap_engine.sv
tb/sv/selection_bitmap_engine_tb.sv
